[design/spdc_pkg.sv]
// shared types and codes for the servo mode pd controller
package spdc_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] REG_SERVO_MODE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_AMPLITUDE_SP = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_VELOCITY_SP  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_POSITION_SP  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_VEL_GAIN_P   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_VEL_GAIN_D   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_POS_GAIN_P   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_POS_GAIN_D   = 3'd7;

   // servo modes
   localparam logic [1:0] MODE_DISABLED  = 2'd0;
   localparam logic [1:0] MODE_AMPLITUDE = 2'd1;
   localparam logic [1:0] MODE_VELOCITY  = 2'd2;
   localparam logic [1:0] MODE_POSITION  = 2'd3;

   localparam int POS_P_SHIFT = 16;
   localparam int POS_D_SHIFT = 8;

   typedef struct packed {
      logic [1:0]         servo_mode;
      logic signed [15:0] amplitude_setpoint;
      logic signed [15:0] velocity_setpoint;
      logic signed [31:0] position_setpoint;
      logic signed [15:0] vel_gain_p;
      logic signed [15:0] vel_gain_d;
      logic signed [15:0] pos_gain_p;
      logic signed [15:0] pos_gain_d;
   } cfg_type;

endpackage

[design/servo_mode_pd_controller_top.sv]
// top level of the servo mode pd controller: three-stage drive pipeline
//
// one req beat per control tick carries the measured velocity and the
// tracked position; each tick in amplitude, velocity or position mode gives
// one rsp beat with the saturated drive, a tick in disabled mode gives none
// but still updates the remembered velocity.
// the csr channel writes the eight mode, setpoint and gain registers; it is
// always ready. the user must see that it is written only while no tick is
// in flight; the block itself has no check for this.
// a result beat passes through the input difference stage, the multiplier
// stage and the result register, and a stall can hold it in any of them.
// throughput: one tick per cycle while rsp_tready does not stall; the
// velocity-mode drive feedback closes in the final add and saturate stage,
// so back-to-back ticks see the drive of the tick before.
// when rsp_tready is low the stages fill bubble by bubble, and req_tready
// drops only once all three stages hold a beat.
// reset clears the registers, the remembered velocity and drive, and empties
// the pipeline.
module servo_mode_pd_controller_top #(
   parameter int DRIVE_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: measured_velocity [15:0], measured_position [47:16]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [47:0]                        req_tdata,
   // rsp_tdata: drive_amplitude [DRIVE_WIDTH-1:0], zero fill above
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [((DRIVE_WIDTH+7)/8)*8-1:0]   rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [spdc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [spdc_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int RSP_W = ((DRIVE_WIDTH + 7) / 8) * 8;
   localparam int SUM_W = 56;
   localparam logic signed [SUM_W-1:0] DRV_MAX =
      {{(SUM_W-DRIVE_WIDTH+1){1'b0}}, {(DRIVE_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] DRV_MIN = ~DRV_MAX;

   spdc_pkg::cfg_type cfg;

   spdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   function automatic logic signed [DRIVE_WIDTH-1:0] sat_drive(
      input logic signed [SUM_W-1:0] x
   );
      logic signed [SUM_W-1:0] y;
      if (x > DRV_MAX) begin
         y = DRV_MAX;
      end else if (x < DRV_MIN) begin
         y = DRV_MIN;
      end else begin
         y = x;
      end
      return y[DRIVE_WIDTH-1:0];
   endfunction

   logic signed [15:0] req_vel;
   logic signed [31:0] req_pos;
   assign req_vel = req_tdata[15:0];
   assign req_pos = req_tdata[47:16];

   // handshake and stage enables
   logic req_beat;
   logic out_adv;
   logic s2_adv;
   logic s1_adv;

   // stage 1: differences
   logic               s1_valid_ff;
   logic [1:0]         s1_mode_ff;
   logic signed [16:0] s1_err_ff;
   logic signed [16:0] s1_delta_ff;
   logic signed [32:0] s1_perr_ff;
   logic signed [15:0] s1_vel_ff;
   logic signed [15:0] prev_vel_ff;

   // stage 2: products
   logic               s2_valid_ff;
   logic [1:0]         s2_mode_ff;
   logic signed [32:0] s2_pa_ff;
   logic signed [32:0] s2_pb_ff;
   logic signed [48:0] s2_pp_ff;
   logic signed [31:0] s2_pd_ff;

   // stage 3: result register and velocity-mode drive memory
   logic                          rsp_valid_ff;
   logic signed [DRIVE_WIDTH-1:0] rsp_drive_ff;
   logic signed [DRIVE_WIDTH-1:0] prev_drive_ff;
   logic signed [DRIVE_WIDTH-1:0] drive_in;

   assign out_adv    = !rsp_valid_ff || rsp_tready;
   assign s2_adv     = !s2_valid_ff || out_adv;
   assign s1_adv     = !s1_valid_ff || s2_adv;
   assign req_tready = s1_adv;
   assign req_beat   = req_tvalid && s1_adv;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'($unsigned(rsp_drive_ff));

   // stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         prev_vel_ff <= '0;
      end else if (s1_adv) begin
         // disabled ticks leave the pipeline here
         s1_valid_ff <= req_tvalid && (cfg.servo_mode != spdc_pkg::MODE_DISABLED);
         if (req_beat) begin
            prev_vel_ff <= req_vel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_mode_ff  <= cfg.servo_mode;
         s1_vel_ff   <= req_vel;
         s1_err_ff   <= 17'(req_vel) - 17'(cfg.velocity_setpoint);
         s1_delta_ff <= 17'(req_vel) - 17'(prev_vel_ff);
         s1_perr_ff  <= 33'(req_pos) - 33'(cfg.position_setpoint);
      end
   end

   // stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv && s1_valid_ff) begin
         s2_mode_ff <= s1_mode_ff;
         s2_pa_ff   <= 33'(s1_err_ff) * 33'(cfg.vel_gain_p);
         s2_pb_ff   <= 33'(s1_delta_ff) * 33'(cfg.vel_gain_d);
         s2_pp_ff   <= 49'(s1_perr_ff) * 49'(cfg.pos_gain_p);
         s2_pd_ff   <= 32'(s1_vel_ff) * 32'(cfg.pos_gain_d);
      end
   end

   // stage 3: sum and saturate
   logic signed [SUM_W-1:0] vel_sum;
   logic signed [SUM_W-1:0] pos_neg;
   logic signed [SUM_W-1:0] pos_diff;

   always_comb begin
      vel_sum  = SUM_W'(prev_drive_ff) + SUM_W'(s2_pa_ff) + SUM_W'(s2_pb_ff);
      pos_neg  = -SUM_W'(s2_pp_ff);
      pos_diff = (pos_neg >>> spdc_pkg::POS_P_SHIFT)
               - (SUM_W'(s2_pd_ff) >>> spdc_pkg::POS_D_SHIFT);
      case (s2_mode_ff)
         spdc_pkg::MODE_AMPLITUDE: drive_in = sat_drive(SUM_W'(cfg.amplitude_setpoint));
         spdc_pkg::MODE_VELOCITY:  drive_in = sat_drive(vel_sum);
         spdc_pkg::MODE_POSITION:  drive_in = sat_drive(pos_diff);
         default:                  drive_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         prev_drive_ff <= '0;
      end else if (out_adv) begin
         rsp_valid_ff <= s2_valid_ff;
         if (s2_valid_ff && (s2_mode_ff == spdc_pkg::MODE_VELOCITY)) begin
            prev_drive_ff <= drive_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && s2_valid_ff) begin
         rsp_drive_ff <= drive_in;
      end
   end

endmodule

[design/spdc_csr.sv]
// configuration register bank of the servo mode pd controller
module spdc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [spdc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [spdc_pkg::CSR_DATA_W-1:0]    csr_data,
   output spdc_pkg::cfg_type                  cfg
);

   spdc_pkg::cfg_type cfg_ff;
   spdc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            spdc_pkg::REG_SERVO_MODE:   cfg_in.servo_mode         = csr_data[1:0];
            spdc_pkg::REG_AMPLITUDE_SP: cfg_in.amplitude_setpoint = csr_data[15:0];
            spdc_pkg::REG_VELOCITY_SP:  cfg_in.velocity_setpoint  = csr_data[15:0];
            spdc_pkg::REG_POSITION_SP:  cfg_in.position_setpoint  = csr_data[31:0];
            spdc_pkg::REG_VEL_GAIN_P:   cfg_in.vel_gain_p         = csr_data[15:0];
            spdc_pkg::REG_VEL_GAIN_D:   cfg_in.vel_gain_d         = csr_data[15:0];
            spdc_pkg::REG_POS_GAIN_P:   cfg_in.pos_gain_p         = csr_data[15:0];
            spdc_pkg::REG_POS_GAIN_D:   cfg_in.pos_gain_d         = csr_data[15:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[bench/tb_servo_mode_pd_controller_top.sv]
// testbench for the servo mode pd controller: directed and random ticks checked against a predictor
module tb_servo_mode_pd_controller_top;

   localparam int LATENCY_PAD = 8;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [47:0]                      req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [15:0]                      rsp_tdata;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [spdc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [spdc_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;
   int fail_count = 0;

   // predictor copy of the registers and the loop memory
   logic [1:0]         mode_sel = spdc_pkg::MODE_DISABLED;
   logic signed [15:0] amp_sp = '0;
   logic signed [15:0] vel_sp = '0;
   logic signed [31:0] pos_sp = '0;
   logic signed [15:0] vel_kp = '0;
   logic signed [15:0] vel_kd = '0;
   logic signed [15:0] pos_kp = '0;
   logic signed [15:0] pos_kd = '0;
   logic signed [15:0] last_velocity = '0;
   logic signed [15:0] last_vel_drive = '0;
   logic [15:0]        expected_drives[$];

   servo_mode_pd_controller_top #(
      .DRIVE_WIDTH(16)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic signed [15:0] clamp_drive(input longint x);
      if (x > 32767)
         return 16'sh7fff;
      if (x < -32768)
         return 16'sh8000;
      return x[15:0];
   endfunction

   function automatic void predict_drive(input logic signed [15:0] vel,
                                         input logic signed [31:0] pos);
      longint v;
      longint sum;
      longint pterm;
      longint dterm;
      v = vel;
      case (mode_sel)
         spdc_pkg::MODE_AMPLITUDE: expected_drives.push_back(amp_sp);
         spdc_pkg::MODE_VELOCITY: begin
            sum = longint'(last_vel_drive) + (v - vel_sp) * vel_kp
                  + (v - last_velocity) * vel_kd;
            last_vel_drive = clamp_drive(sum);
            expected_drives.push_back(last_vel_drive);
         end
         spdc_pkg::MODE_POSITION: begin
            pterm = (-(longint'(pos) - pos_sp) * pos_kp) >>> spdc_pkg::POS_P_SHIFT;
            dterm = (v * pos_kd) >>> spdc_pkg::POS_D_SHIFT;
            expected_drives.push_back(clamp_drive(pterm - dterm));
         end
         default: ;
      endcase
      last_velocity = vel;
   endfunction

   // result beats against the oldest predicted drive
   always @(posedge clock) begin : drive_check
      logic [15:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_drives.size() == 0) begin
            $display("%0t: unexpected drive beat, expected none, actual %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = expected_drives.pop_front();
            if (rsp_tdata !== want) begin
               $display("%0t: drive mismatch, expected %h, actual %h", $time, want, rsp_tdata);
               fail_count++;
            end
         end
      end
   end

   // receiver: random stalls, or a long hold-off when requested
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      #3000000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic send_tick(input logic signed [15:0] vel, input logic signed [31:0] pos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {pos, vel};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_drive(vel, pos);
      @(negedge clock);
   endtask

   // wait out every expected beat plus ticks that give none
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_drives.size() != 0)
         @(negedge clock);
      repeat (LATENCY_PAD) @(negedge clock);
   endtask

   task automatic write_reg(input logic [spdc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [spdc_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         spdc_pkg::REG_SERVO_MODE:   mode_sel = value[1:0];
         spdc_pkg::REG_AMPLITUDE_SP: amp_sp = value[15:0];
         spdc_pkg::REG_VELOCITY_SP:  vel_sp = value[15:0];
         spdc_pkg::REG_POSITION_SP:  pos_sp = value;
         spdc_pkg::REG_VEL_GAIN_P:   vel_kp = value[15:0];
         spdc_pkg::REG_VEL_GAIN_D:   vel_kd = value[15:0];
         spdc_pkg::REG_POS_GAIN_P:   pos_kp = value[15:0];
         spdc_pkg::REG_POS_GAIN_D:   pos_kd = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_all(input logic [1:0] m, input logic [15:0] amp,
                              input logic [15:0] vsp, input logic [31:0] psp,
                              input logic [15:0] vkp, input logic [15:0] vkd,
                              input logic [15:0] pkp, input logic [15:0] pkd);
      write_reg(spdc_pkg::REG_SERVO_MODE, {30'b0, m});
      write_reg(spdc_pkg::REG_AMPLITUDE_SP, {{16{amp[15]}}, amp});
      write_reg(spdc_pkg::REG_VELOCITY_SP, {{16{vsp[15]}}, vsp});
      write_reg(spdc_pkg::REG_POSITION_SP, psp);
      write_reg(spdc_pkg::REG_VEL_GAIN_P, {{16{vkp[15]}}, vkp});
      write_reg(spdc_pkg::REG_VEL_GAIN_D, {{16{vkd[15]}}, vkd});
      write_reg(spdc_pkg::REG_POS_GAIN_P, {{16{pkp[15]}}, pkp});
      write_reg(spdc_pkg::REG_POS_GAIN_D, {{16{pkd[15]}}, pkd});
   endtask

   function automatic logic [15:0] pick16();
      case ($urandom_range(9))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hffff;
         4, 5: return 16'(int'($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick32();
      case ($urandom_range(9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'h00000000;
         3, 4: return 32'(int'($urandom_range(0, 200000)) - 100000);
         default: return $urandom;
      endcase
   endfunction

   // small gains keep velocity mode off the rails most of the time
   function automatic logic [15:0] pick_gain();
      if ($urandom_range(9) < 6)
         return 16'(int'($urandom_range(0, 16)) - 8);
      return pick16();
   endfunction

   task automatic test_disabled_after_reset();
      send_tick(16'sh7fff, 32'sh80000000);
      send_tick(16'sh8000, 32'sh7fffffff);
      send_tick(16'sd100, 32'sd0);
      settle();
   endtask

   task automatic test_amplitude();
      program_all(spdc_pkg::MODE_AMPLITUDE, 16'h7fff, 16'd0, 32'd0, 16'd0, 16'd0,
                  16'd0, 16'd0);
      send_tick(16'sd5, 32'sd5);
      settle();
      write_reg(spdc_pkg::REG_AMPLITUDE_SP, 32'hffff8000);
      send_tick(16'sd0, 32'sd0);
      settle();
      write_reg(spdc_pkg::REG_AMPLITUDE_SP, 32'h0);
      send_tick(16'sh8000, 32'sh80000000);
      settle();
   endtask

   task automatic test_velocity();
      // error is measured minus setpoint
      program_all(spdc_pkg::MODE_VELOCITY, 16'd0, 16'd100, 32'd0, 16'd1, 16'd0,
                  16'd0, 16'd0);
      send_tick(16'sd101, 32'sd0);
      send_tick(16'sd99, 32'sd0);
      settle();
      write_reg(spdc_pkg::REG_VEL_GAIN_P, 32'h0);
      write_reg(spdc_pkg::REG_VEL_GAIN_D, 32'd2);
      send_tick(16'sd109, 32'sd0);
      settle();
      // full-range differences must not wrap before saturation
      program_all(spdc_pkg::MODE_VELOCITY, 16'd0, 16'h8000, 32'd0, 16'h7fff, 16'h7fff,
                  16'd0, 16'd0);
      send_tick(16'sh7fff, 32'sd0);
      settle();
      write_reg(spdc_pkg::REG_VELOCITY_SP, 32'h00007fff);
      send_tick(16'sh8000, 32'sd0);
      settle();
   endtask

   task automatic test_position();
      // right shifts round toward minus infinity
      program_all(spdc_pkg::MODE_POSITION, 16'd0, 16'd0, 32'd0, 16'd0, 16'd0,
                  16'd1, 16'd0);
      send_tick(16'sd0, 32'sd1);
      send_tick(16'sd0, -32'sd1);
      settle();
      write_reg(spdc_pkg::REG_POS_GAIN_P, 32'h0);
      write_reg(spdc_pkg::REG_POS_GAIN_D, 32'd1);
      send_tick(-16'sd1, 32'sd0);
      settle();
      program_all(spdc_pkg::MODE_POSITION, 16'd0, 16'd0, 32'h7fffffff, 16'd0, 16'd0,
                  16'h8000, 16'h7fff);
      send_tick(16'sh8000, 32'sh80000000);
      settle();
      write_reg(spdc_pkg::REG_POS_GAIN_P, 32'h00007fff);
      send_tick(16'sh7fff, 32'sh80000000);
      settle();
   endtask

   // drive memory survives other modes, velocity memory updates even when disabled
   task automatic test_mode_memory();
      program_all(spdc_pkg::MODE_VELOCITY, 16'd7, 16'd0, 32'd0, 16'd1, 16'd1,
                  16'd3, 16'd3);
      send_tick(16'sd50, 32'sd0);
      settle();
      write_reg(spdc_pkg::REG_SERVO_MODE, {30'b0, spdc_pkg::MODE_DISABLED});
      send_tick(16'sd10, 32'sd0);
      settle();
      write_reg(spdc_pkg::REG_SERVO_MODE, {30'b0, spdc_pkg::MODE_VELOCITY});
      send_tick(16'sd20, 32'sd0);
      settle();
      write_reg(spdc_pkg::REG_SERVO_MODE, {30'b0, spdc_pkg::MODE_POSITION});
      send_tick(-16'sd300, 32'sd70000);
      settle();
      write_reg(spdc_pkg::REG_SERVO_MODE, {30'b0, spdc_pkg::MODE_VELOCITY});
      send_tick(16'sd25, 32'sd0);
      settle();
   endtask

   task automatic test_random(input int n_items);
      int sent;
      int seg;
      logic [1:0] m;
      logic [31:0] pos;
      sent = 0;
      while (sent < n_items) begin
         m = ($urandom_range(7) == 0) ? spdc_pkg::MODE_DISABLED : 2'($urandom_range(1, 3));
         program_all(m, pick16(), pick16(), pick32(), pick_gain(), pick_gain(),
                     pick_gain(), pick_gain());
         seg = $urandom_range(8, 40);
         repeat (seg) begin
            if ($urandom_range(1) == 1)
               pos = pos_sp + 32'(int'($urandom_range(0, 4000)) - 2000);
            else
               pos = pick32();
            send_tick(pick16(), pos);
         end
         sent += seg;
         settle();
      end
   endtask

   // long receiver hold-off while ticks keep coming, so the pipeline fills
   task automatic test_backpressure();
      program_all(spdc_pkg::MODE_VELOCITY, 16'd0, pick16(), pick32(), pick_gain(),
                  pick_gain(), pick_gain(), pick_gain());
      hold_cycles = 200;
      repeat (40) send_tick(pick16(), pick32());
      settle();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 17;
      recv_idle_pct = 52;
      test_disabled_after_reset();
      test_amplitude();
      test_velocity();
      test_position();
      test_mode_memory();
      test_random(300);

      send_idle_pct = 52;
      recv_idle_pct = 17;
      test_random(300);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random(300);

      settle();
      if (fail_count == 0 && expected_drives.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
